// ----- rtl/core/tpia_pkg.sv -----
// ----------------------------------------------------------------------------
// tpia_pkg
// shared types and codes for the two pool id allocator
// ----------------------------------------------------------------------------
package tpia_pkg;

    localparam int ID_W   = 16;
    localparam int CFG_IW = 2;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_DEVICE  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_POOL_FULL   = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_NOT_ALLOC   = 2'd3
    } status_t;

    typedef enum logic {
        POOL_COMMON  = 1'b0,
        POOL_SPECIAL = 1'b1
    } pool_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_COMMON_BASE  = 2'd0,
        REG_SPECIAL_BASE = 2'd1,
        REG_DEVICE_START = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]      action;
        logic            pool;
        logic [ID_W-1:0] release_id;
    } req_item_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] given_id;
    } rsp_item_t;

endpackage

// ----- rtl/core/two_pool_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// two_pool_id_allocator_top
// lowest-free-slot id allocator over two bitmap pools plus a device counter
// ----------------------------------------------------------------------------
// A request beat is captured into an input register; on the next cycle the
// free bitmaps are searched, the range check is done and the device number
// is formed in one short pass, and the response lands in the output
// register, so a response passes the input and then the output register.
// One request is taken every cycle while responses are drained: the bitmaps
// and the counter update at the same edge that loads the response, so the
// following request already sees them. A stalled response holds the pipe;
// the request side keeps taking one beat into the input register meanwhile.
// Configuration writes (common_base, special_base, device_start) are always
// ready and take effect at once; indexes beyond the list are dropped.
// After reset every slot of both pools is free and the counter is zero.
module two_pool_id_allocator_top
    import tpia_pkg::*;
#(
    parameter int COMMON_SLOTS  = 32,
    parameter int SPECIAL_SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  req_item_t         req_data,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_item_t         rsp_data,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [ID_W-1:0]   cfg_data
);

    // slot index widths, at least one bit
    localparam int C_IDX_W = (COMMON_SLOTS  > 1) ? $clog2(COMMON_SLOTS)  : 1;
    localparam int S_IDX_W = (SPECIAL_SLOTS > 1) ? $clog2(SPECIAL_SLOTS) : 1;

    // configuration registers
    logic [ID_W-1:0] common_base_reg;
    logic [ID_W-1:0] special_base_reg;
    logic [ID_W-1:0] device_start_reg;

    // allocator state
    logic [COMMON_SLOTS-1:0]  common_map_reg,  common_map_next;
    logic [SPECIAL_SLOTS-1:0] special_map_reg, special_map_next;
    logic [ID_W-1:0]          device_count_reg, device_count_next;

    // input register
    logic      hold_valid_reg;
    req_item_t hold_data_reg;

    // output register
    logic      rsp_valid_reg;
    rsp_item_t rsp_data_reg;
    rsp_item_t rsp_next;

    logic advance;
    logic work;

    // pipe moves when the response slot is empty or being taken
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign work      = hold_valid_reg && advance;
    assign req_ready = !hold_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // lowest free slot of each pool
    logic               c_found, s_found;
    logic [C_IDX_W-1:0] c_first;
    logic [S_IDX_W-1:0] s_first;

    always_comb
    begin
        c_found = |common_map_reg;
        c_first = '0;
        for (int i = COMMON_SLOTS - 1; i >= 0; i--)
        begin
            if (common_map_reg[i])
            begin
                c_first = C_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        s_found = |special_map_reg;
        s_first = '0;
        for (int i = SPECIAL_SLOTS - 1; i >= 0; i--)
        begin
            if (special_map_reg[i])
            begin
                s_first = S_IDX_W'(i);
            end
        end
    end

    // release range check in full precision: borrow means below the base
    logic [ID_W:0]      c_offset, s_offset;
    logic               c_out_range, s_out_range;
    logic [C_IDX_W-1:0] c_rel_idx;
    logic [S_IDX_W-1:0] s_rel_idx;

    assign c_offset    = {1'b0, hold_data_reg.release_id} - {1'b0, common_base_reg};
    assign s_offset    = {1'b0, hold_data_reg.release_id} - {1'b0, special_base_reg};
    assign c_out_range = c_offset[ID_W] || (c_offset[ID_W-1:0] >= ID_W'(COMMON_SLOTS));
    assign s_out_range = s_offset[ID_W] || (s_offset[ID_W-1:0] >= ID_W'(SPECIAL_SLOTS));
    assign c_rel_idx   = c_offset[C_IDX_W-1:0];
    assign s_rel_idx   = s_offset[S_IDX_W-1:0];

    // one pass over the held request
    always_comb
    begin
        common_map_next   = common_map_reg;
        special_map_next  = special_map_reg;
        device_count_next = device_count_reg;
        rsp_next.status   = ST_OK;
        rsp_next.given_id = '0;

        unique case (action_t'(hold_data_reg.action))
            ACT_ALLOC:
            begin
                if (hold_data_reg.pool == POOL_SPECIAL)
                begin
                    if (!s_found)
                    begin
                        rsp_next.status = ST_POOL_FULL;
                    end
                    else
                    begin
                        special_map_next[s_first] = 1'b0;
                        rsp_next.given_id = special_base_reg + ID_W'(s_first);
                    end
                end
                else
                begin
                    if (!c_found)
                    begin
                        rsp_next.status = ST_POOL_FULL;
                    end
                    else
                    begin
                        common_map_next[c_first] = 1'b0;
                        rsp_next.given_id = common_base_reg + ID_W'(c_first);
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (hold_data_reg.pool == POOL_SPECIAL)
                begin
                    if (s_out_range)
                    begin
                        rsp_next.status = ST_OUT_OF_RANGE;
                    end
                    else if (special_map_reg[s_rel_idx])
                    begin
                        rsp_next.status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        special_map_next[s_rel_idx] = 1'b1;
                    end
                end
                else
                begin
                    if (c_out_range)
                    begin
                        rsp_next.status = ST_OUT_OF_RANGE;
                    end
                    else if (common_map_reg[c_rel_idx])
                    begin
                        rsp_next.status = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        common_map_next[c_rel_idx] = 1'b1;
                    end
                end
            end
            ACT_DEVICE:
            begin
                rsp_next.given_id = device_start_reg + device_count_reg;
                device_count_next = device_count_reg + ID_W'(1);
            end
            default:
            begin
                // unused action code
                rsp_next.status = ST_OUT_OF_RANGE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_base_reg  <= ID_W'(1);
            special_base_reg <= ID_W'(33);
            device_start_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COMMON_BASE:  common_base_reg  <= cfg_data;
                REG_SPECIAL_BASE: special_base_reg <= cfg_data;
                REG_DEVICE_START: device_start_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // allocator state and pipe control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_map_reg   <= '1;
            special_map_reg  <= '1;
            device_count_reg <= '0;
            hold_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (work)
            begin
                common_map_reg   <= common_map_next;
                special_map_reg  <= special_map_next;
                device_count_reg <= device_count_next;
            end
            if (req_ready)
            begin
                hold_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= hold_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            hold_data_reg <= req_data;
        end
        if (work)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

endmodule

// ----- rtl/core/tpia_checker.sv -----
// ----------------------------------------------------------------------------
// tpia_checker
// port-level checks for the two pool id allocator
// ----------------------------------------------------------------------------
module tpia_checker
    import tpia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_item_t         rsp_data
);

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response beat changed while stalled");

    // any error status gives no id
    a_err_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.given_id == '0)
        else $error("error response carries an id");

    // an empty response slot never blocks requests
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request side stalled with response slot empty");

    // no response appears without an earlier request beat or a held one
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(rsp_valid, 2)
                             || $past(req_valid, 2))
        else $error("response without a request");

endmodule

bind two_pool_id_allocator_top tpia_checker u_tpia_checker (.*);

// ----- tb/two_pool_id_allocator_top_test.sv -----
// ----------------------------------------------------------------------------
// two_pool_id_allocator_top_test
// self-checking bench for the two pool id allocator: a directed table covers
// reset values, range edges, wrap cases and a full pool, then random phases
// under different base settings compare every response beat to a predictor
// ----------------------------------------------------------------------------
module two_pool_id_allocator_top_test;
    import tpia_pkg::*;

    localparam int COMMON_SLOTS  = 32;
    localparam int SPECIAL_SLOTS = 32;

    // run shape
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_PHASE   = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;

    // codes the package leaves unnamed
    localparam logic [1:0]        ACT_SPARE = 2'd3;
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

    // legal base range of the registers
    localparam logic [ID_W-1:0] BASE_LO = 16'd1;
    localparam logic [ID_W-1:0] BASE_HI = 16'd65503;

    // one row of the directed table: either a register write or a request
    // repeated reps times, with a typed-in response where typed is set
    typedef struct packed {
        logic            is_cfg;
        logic [1:0]      code;
        logic            pool;
        logic [ID_W-1:0] value;
        logic [7:0]      reps;
        logic            typed;
        logic [1:0]      want_status;
        logic [ID_W-1:0] want_id;
    } dir_step_t;

    localparam int DIR_ROWS = 27;
    localparam dir_step_t DIRECTED [DIR_ROWS] = '{
        // reset bases: common from 1, special from 33, devices from 0
        '{1'b0, ACT_ALLOC,   POOL_COMMON,  16'h0000, 8'd1,  1'b1, ST_OK,           16'd1},
        '{1'b0, ACT_ALLOC,   POOL_SPECIAL, 16'h0000, 8'd1,  1'b1, ST_OK,           16'd33},
        '{1'b0, ACT_DEVICE,  POOL_COMMON,  16'h0000, 8'd1,  1'b1, ST_OK,           16'd0},
        '{1'b0, ACT_DEVICE,  POOL_SPECIAL, 16'hFFFF, 8'd1,  1'b1, ST_OK,           16'd1},
        // range edges of both pools, and an unused action code
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd0,    8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd33,   8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd32,   8'd1,  1'b1, ST_NOT_ALLOC,    16'd0},
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd1,    8'd1,  1'b1, ST_OK,           16'd0},
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd1,    8'd1,  1'b1, ST_NOT_ALLOC,    16'd0},
        '{1'b0, ACT_RELEASE, POOL_SPECIAL, 16'hFFFF, 8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        '{1'b0, ACT_RELEASE, POOL_SPECIAL, 16'd32,   8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        '{1'b0, ACT_SPARE,   POOL_SPECIAL, 16'hFFFF, 8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        // fill the special pool, then one more, then free and retake its top slot
        '{1'b0, ACT_ALLOC,   POOL_SPECIAL, 16'h0000, 8'd31, 1'b0, ST_OK,           16'd0},
        '{1'b0, ACT_ALLOC,   POOL_SPECIAL, 16'h0000, 8'd1,  1'b1, ST_POOL_FULL,    16'd0},
        '{1'b0, ACT_RELEASE, POOL_SPECIAL, 16'd64,   8'd1,  1'b1, ST_OK,           16'd0},
        '{1'b0, ACT_ALLOC,   POOL_SPECIAL, 16'h0000, 8'd1,  1'b1, ST_OK,           16'd64},
        // bases at the very ends of the field, device start at its top
        '{1'b1, REG_COMMON_BASE,  1'b0,    16'hFFFF, 8'd1,  1'b0, ST_OK,           16'd0},
        '{1'b1, REG_SPECIAL_BASE, 1'b0,    16'h0000, 8'd1,  1'b0, ST_OK,           16'd0},
        '{1'b1, REG_DEVICE_START, 1'b0,    16'hFFFF, 8'd1,  1'b0, ST_OK,           16'd0},
        '{1'b1, REG_SPARE,        1'b0,    16'hA5A5, 8'd1,  1'b0, ST_OK,           16'd0},
        // id wraps past the top of 16 bits
        '{1'b0, ACT_ALLOC,   POOL_COMMON,  16'h0000, 8'd1,  1'b1, ST_OK,           16'hFFFF},
        '{1'b0, ACT_ALLOC,   POOL_COMMON,  16'h0000, 8'd1,  1'b1, ST_OK,           16'd0},
        // range test in full precision: 0 is below a base of 0xffff
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'd0,    8'd1,  1'b1, ST_OUT_OF_RANGE, 16'd0},
        '{1'b0, ACT_RELEASE, POOL_COMMON,  16'hFFFF, 8'd1,  1'b1, ST_OK,           16'd0},
        // device ids wrap past the top, then slot 0 of the special pool at base 0
        '{1'b0, ACT_DEVICE,  POOL_COMMON,  16'h0000, 8'd2,  1'b0, ST_OK,           16'd0},
        '{1'b0, ACT_RELEASE, POOL_SPECIAL, 16'd0,    8'd1,  1'b1, ST_OK,           16'd0},
        '{1'b0, ACT_ALLOC,   POOL_SPECIAL, 16'h0000, 8'd1,  1'b1, ST_OK,           16'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_item_t         req_data;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_item_t         rsp_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [ID_W-1:0]   cfg_data;

    // bench copy of the allocator state and registers
    logic [COMMON_SLOTS-1:0]  common_vacant;
    logic [SPECIAL_SLOTS-1:0] special_vacant;
    logic [ID_W-1:0]          common_base;
    logic [ID_W-1:0]          special_base;
    logic [ID_W-1:0]          device_start;
    logic [ID_W-1:0]          device_count;

    // responses still owed by the block, oldest first
    rsp_item_t grants_due [$];
    rsp_item_t next_grant;
    rsp_item_t owed;

    // typed-in response travelling with the current request beat
    logic      tag_typed;
    rsp_item_t tag_grant;

    int errors;
    int cycle_count;

    // flags from the stimulus thread to the response side
    bit quiet;
    bit tx_gappy;
    bit hold_off_due;

    two_pool_id_allocator_top #(
        .COMMON_SLOTS  (COMMON_SLOTS),
        .SPECIAL_SLOTS (SPECIAL_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // response to one request beat, advancing the bench state
    function automatic rsp_item_t predict_grant(input req_item_t r);
        rsp_item_t   g;
        logic [63:0] vacant;
        int unsigned base;
        int unsigned slots;
        int unsigned rid;
        int unsigned slot;
        bit          special;
        special    = (r.pool == POOL_SPECIAL);
        base       = special ? 32'(special_base) : 32'(common_base);
        slots      = special ? SPECIAL_SLOTS : COMMON_SLOTS;
        vacant     = '0;
        vacant     = special ? 64'(special_vacant) : 64'(common_vacant);
        rid        = 32'(r.release_id);
        g.status   = ST_OK;
        g.given_id = '0;
        case (r.action)
            ACT_ALLOC:
            begin
                if (vacant == 64'd0)
                    g.status = ST_POOL_FULL;
                else
                begin
                    // lowest free slot wins
                    slot = 0;
                    while (!vacant[slot])
                        slot++;
                    vacant[slot] = 1'b0;
                    g.given_id   = ID_W'(base + slot);
                end
            end
            ACT_RELEASE:
            begin
                // no 16-bit wrap in the range test
                if (rid < base || rid - base >= slots)
                    g.status = ST_OUT_OF_RANGE;
                else if (vacant[rid - base])
                    g.status = ST_NOT_ALLOC;
                else
                    vacant[rid - base] = 1'b1;
            end
            ACT_DEVICE:
            begin
                g.given_id   = device_start + device_count;
                device_count = device_count + 1'b1;
            end
            default:
                g.status = ST_OUT_OF_RANGE;
        endcase
        if (special)
            special_vacant = vacant[SPECIAL_SLOTS-1:0];
        else
            common_vacant = vacant[COMMON_SLOTS-1:0];
        return g;
    endfunction

    // every beat is observed on the rising edge with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COMMON_BASE:  common_base  = cfg_data;
                    REG_SPECIAL_BASE: special_base = cfg_data;
                    REG_DEVICE_START: device_start = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                // predictor always runs so its state follows the block
                next_grant = predict_grant(req_data);
                if (tag_typed)
                    next_grant = tag_grant;
                grants_due.push_back(next_grant);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (grants_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response beat, expected none actual status %0d id %0d",
                             $time, rsp_data.status, rsp_data.given_id);
                end
                else
                begin
                    owed = grants_due.pop_front();
                    if (rsp_data.status !== owed.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, owed.status, rsp_data.status);
                    end
                    if (rsp_data.given_id !== owed.given_id)
                    begin
                        errors++;
                        $display("%0t: given_id mismatch, expected %0d actual %0d",
                                 $time, owed.given_id, rsp_data.given_id);
                    end
                end
            end
        end
    end

    // response side: random stall bursts, calm stretches, one long hold-off
    initial
    begin
        int stall_left;
        bit calm;
        rsp_ready  = 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_due)
            begin
                // long back-pressure so the pipe fills and req_ready drops
                hold_off_due = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (!quiet && $urandom_range(0, 199) == 0)
                calm = !calm;
            if (stall_left == 0 && !quiet && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // drop valid and pause the sender, n sets the length of the pause
    task automatic pause_sender(input int n);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // present one request beat and hold it until accepted
    task automatic offer(input req_item_t item, input logic typed, input rsp_item_t want);
        if (!quiet && tx_gappy && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 16));
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= item;
        tag_typed <= typed;
        tag_grant <= want;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // stop offering and let every owed response come back
    task automatic await_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (grants_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [ID_W-1:0] val);
        await_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random request, mostly well formed against the current bases
    function automatic req_item_t random_request();
        req_item_t       it;
        int unsigned     pick;
        int unsigned     slots;
        logic [ID_W-1:0] base;
        it.pool       = 1'($urandom_range(0, 1));
        it.release_id = ID_W'($urandom);
        it.action     = ACT_ALLOC;
        base          = it.pool ? special_base : common_base;
        slots         = it.pool ? SPECIAL_SLOTS : COMMON_SLOTS;
        pick          = $urandom_range(0, 99);
        if (pick < 40)
            it.action = ACT_ALLOC;
        else if (pick < 75)
        begin
            it.action     = ACT_RELEASE;
            it.release_id = ID_W'(base + $urandom_range(0, slots - 1));
        end
        else if (pick < 80)
        begin
            // just outside the pool on either side
            it.action     = ACT_RELEASE;
            it.release_id = pick[0] ? ID_W'(base - 1) : ID_W'(base + slots);
        end
        else if (pick < 88)
            it.action = ACT_RELEASE;
        else if (pick < 96)
            it.action = ACT_DEVICE;
        else
            it.action = ACT_SPARE;
        return it;
    endfunction

    // random traffic with occasional fill and drain runs on one pool
    task automatic run_phase(input int n);
        int              sent;
        int              k;
        int              slots;
        int unsigned     pick;
        req_item_t       it;
        logic [ID_W-1:0] base;
        sent = 0;
        while (sent < n)
        begin
            pick    = $urandom_range(0, 199);
            it.pool = 1'($urandom_range(0, 1));
            base    = it.pool ? special_base : common_base;
            slots   = it.pool ? SPECIAL_SLOTS : COMMON_SLOTS;
            if (pick == 0)
            begin
                // run past full
                it.action = ACT_ALLOC;
                k = $urandom_range(slots, slots + 8);
                repeat (k)
                begin
                    it.release_id = ID_W'($urandom);
                    offer(it, 1'b0, '0);
                end
                sent += k;
            end
            else if (pick == 1)
            begin
                // give back the whole pool in order
                it.action = ACT_RELEASE;
                for (k = 0; k < slots; k++)
                begin
                    it.release_id = ID_W'(base + k);
                    offer(it, 1'b0, '0);
                end
                sent += slots;
            end
            else
            begin
                offer(random_request(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // stimulus thread
    initial
    begin
        req_item_t       item;
        rsp_item_t       want;
        logic [ID_W-1:0] cb;
        logic [ID_W-1:0] sb;
        logic [ID_W-1:0] ds;
        int              row;
        int              p;

        req_valid      = 1'b0;
        req_data       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        tag_typed      = 1'b0;
        tag_grant      = '0;
        quiet          = 1'b0;
        tx_gappy       = 1'b1;
        hold_off_due   = 1'b0;
        errors         = 0;
        cycle_count    = 0;

        // state after reset
        common_vacant  = '1;
        special_vacant = '1;
        common_base    = 16'd1;
        special_base   = 16'd33;
        device_start   = 16'd0;
        device_count   = 16'd0;

        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (row = 0; row < DIR_ROWS; row++)
        begin
            if (DIRECTED[row].is_cfg)
                write_reg(DIRECTED[row].code, DIRECTED[row].value);
            else
            begin
                item.action     = DIRECTED[row].code;
                item.pool       = DIRECTED[row].pool;
                item.release_id = DIRECTED[row].value;
                want.status     = DIRECTED[row].want_status;
                want.given_id   = DIRECTED[row].want_id;
                repeat (DIRECTED[row].reps)
                    offer(item, DIRECTED[row].typed, want);
            end
        end

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    cb = BASE_LO;
                    sb = BASE_HI;
                    ds = 16'd0;
                end
                1:
                begin
                    cb = BASE_HI;
                    sb = BASE_LO;
                    ds = 16'hFFFF;
                end
                2:
                begin
                    // beyond the legal range, ids wrap near the top
                    cb = 16'hFFF0;
                    sb = 16'h0000;
                    ds = ID_W'($urandom);
                end
                default:
                begin
                    cb = ID_W'($urandom_range(BASE_LO, BASE_HI));
                    sb = ID_W'($urandom_range(BASE_LO, BASE_HI));
                    ds = ID_W'($urandom);
                end
            endcase
            write_reg(REG_COMMON_BASE, cb);
            write_reg(REG_SPECIAL_BASE, sb);
            write_reg(REG_DEVICE_START, ds);
            @(posedge clk);
            if (p == HOLD_PHASE)
                hold_off_due = 1'b1;
            // last phase runs at full rate on both sides
            quiet    = (p == PHASES - 1);
            tx_gappy = 1'($urandom_range(0, 1));
            run_phase(PHASE_ITEMS);
        end

        await_idle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tpia_pkg.sv
rtl/core/two_pool_id_allocator_top.sv
rtl/core/tpia_checker.sv
tb/two_pool_id_allocator_top_test.sv
